// ===== rtl/core/sgdcb_pkg.sv =====
// Shared types, constants and helpers of the descriptor chain builder.
package sgdcb_pkg;

  localparam int unsigned MAX_DESCRIPTORS_DEFAULT = 128;
  localparam logic [7:0]  ADJ_LIMIT               = 8'd64;
  localparam int unsigned DESC_SHIFT              = 5;
  localparam logic [4:0]  LAST_CONTROL            = 5'h13;
  localparam int unsigned PADDR_W                 = 5;

  typedef enum logic [1:0] {
    REG_RING_BASE     = 2'd0,
    REG_TO_DEVICE     = 2'd1,
    REG_DEVICE_START  = 2'd2,
    REG_ELEMENT_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] ring_base;
    logic        to_device;
    logic [63:0] device_start;
    logic [7:0]  element_count;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  next_adjacent;
    logic [4:0]  control_bits;
    logic [27:0] desc_length;
    logic [63:0] source_address;
    logic [63:0] dest_address;
    logic [63:0] link_address;
    logic [6:0]  desc_index;
    logic        is_last;
  } desc_t;

  function automatic logic [6:0] min_limit(input logic [7:0] c);
    return (c < ADJ_LIMIT) ? c[6:0] : ADJ_LIMIT[6:0];
  endfunction

endpackage

// ===== rtl/core/sgdcb_cfg_regs.sv =====
// Configuration register file with its APB-style access port.
module sgdcb_cfg_regs
  import sgdcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t sel_reg;
  logic     wr_en;

  assign sel_reg = reg_idx_t'(paddr[4:3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_base     <= 64'd0;
      cfg.to_device     <= 1'b1;
      cfg.device_start  <= 64'd0;
      cfg.element_count <= 8'd1;
    end else if (wr_en) begin
      case (sel_reg)
        REG_RING_BASE:     cfg.ring_base     <= pwdata;
        REG_TO_DEVICE:     cfg.to_device     <= pwdata[0];
        REG_DEVICE_START:  cfg.device_start  <= pwdata;
        REG_ELEMENT_COUNT: cfg.element_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_reg)
      REG_RING_BASE:     prdata = cfg.ring_base;
      REG_TO_DEVICE:     prdata = {63'd0, cfg.to_device};
      REG_DEVICE_START:  prdata = cfg.device_start;
      REG_ELEMENT_COUNT: prdata = {56'd0, cfg.element_count};
      default:           prdata = 64'd0;
    endcase
  end

endmodule

// ===== rtl/core/sgdcb_in_reg.sv =====
// Input register that holds one scatter-gather word until the engine takes it.
module sgdcb_in_reg
  import sgdcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] host_address,
  input  logic [27:0] byte_length,
  input  logic        take,
  output logic        held_valid,
  output logic [63:0] held_host,
  output logic [27:0] held_length
);

  logic load;

  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_host   <= host_address;
      held_length <= byte_length;
    end
  end

endmodule

// ===== rtl/core/sgdcb_desc_engine.sv =====
// Chain state, descriptor computation and the result register.
module sgdcb_desc_engine
  import sgdcb_pkg::*;
#(
  parameter int unsigned MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        held_valid,
  input  logic [63:0] held_host,
  input  logic [27:0] held_length,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output desc_t       desc
);

  localparam int unsigned IdxW   = $clog2(MAX_DESCRIPTORS);
  localparam int unsigned CntCap = (MAX_DESCRIPTORS < 255) ? MAX_DESCRIPTORS : 255;
  localparam logic [7:0]  CapCnt = 8'(CntCap);

  logic            armed;
  logic [IdxW-1:0] idx;
  logic [63:0]     rda;
  logic [6:0]      adj;
  logic [7:0]      rem;

  logic [7:0]      cnt;
  logic [IdxW-1:0] e_idx;
  logic [63:0]     e_rda;
  logic [6:0]      e_adj;
  logic [7:0]      e_rem;
  logic            last;
  logic [IdxW:0]   idx_p1;
  logic [6:0]      adj_base;
  logic [6:0]      adj_next;
  logic [63:0]     rda_next;
  desc_t           desc_next;

  assign take = held_valid && (!out_valid || !out_stall);

  always_comb begin
    if (cfg.element_count == 8'd0) begin
      cnt = 8'd1;
    end else if (cfg.element_count > CapCnt) begin
      cnt = CapCnt;
    end else begin
      cnt = cfg.element_count;
    end

    e_idx = armed ? '0 : idx;
    e_rda = armed ? cfg.device_start : rda;
    e_rem = armed ? cnt : rem;
    e_adj = armed ? (min_limit(cnt) - 7'd1) : adj;

    last     = (e_rem <= 8'd1);
    idx_p1   = {1'b0, e_idx} + {{IdxW{1'b0}}, 1'b1};
    adj_base = (e_adj == 7'd0) ? min_limit(e_rem) : e_adj;
    adj_next = adj_base - 7'd1;
    rda_next = e_rda + {36'd0, held_length};

    desc_next.next_adjacent = e_adj;
    desc_next.control_bits  = last ? LAST_CONTROL : 5'd0;
    desc_next.desc_length   = held_length;
    if (cfg.to_device) begin
      desc_next.source_address = held_host;
      desc_next.dest_address   = e_rda;
    end else begin
      desc_next.source_address = e_rda;
      desc_next.dest_address   = held_host;
    end
    desc_next.link_address = last ? 64'd0
                           : cfg.ring_base + (64'(idx_p1) << DESC_SHIFT);
    desc_next.desc_index   = 7'(e_idx);
    desc_next.is_last      = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b1;
    end else if (take) begin
      armed <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      adj <= adj_next;
      rda <= rda_next;
      if (last) begin
        idx <= '0;
        rem <= 8'd0;
      end else begin
        idx <= idx_p1[IdxW-1:0];
        rem <= e_rem - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc <= desc_next;
    end
  end

endmodule

// ===== rtl/core/sg_descriptor_chain_builder_unit.sv =====
// Top level of the scatter-gather descriptor chain builder.
//
// Each accepted word (host address and byte length) yields one DMA descriptor,
// one word per clock sustained while out_stall is low: the word is captured in
// the input register and passes through the descriptor logic into the result
// register. The running device address, ring index and adjacent count form a
// loop from their registers through that logic and back, which sets the rate.
// The first word of a transfer loads the chain state from the registers, so
// writes to the device start and element count take effect at the next
// transfer, while the ring base and direction are used as they stand for every
// word; after the descriptor marked last the block rearms on its own.
module sg_descriptor_chain_builder_unit
  import sgdcb_pkg::*;
#(
  parameter int unsigned MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        host_address,
  input  logic [27:0]        byte_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         next_adjacent,
  output logic [4:0]         control_bits,
  output logic [27:0]        desc_length,
  output logic [63:0]        source_address,
  output logic [63:0]        dest_address,
  output logic [63:0]        link_address,
  output logic [6:0]         desc_index,
  output logic               is_last
);

  cfg_t        cfg;
  logic        take;
  logic        held_valid;
  logic [63:0] held_host;
  logic [27:0] held_length;
  desc_t       desc;

  sgdcb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgdcb_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .host_address (host_address),
    .byte_length  (byte_length),
    .take         (take),
    .held_valid   (held_valid),
    .held_host    (held_host),
    .held_length  (held_length)
  );

  sgdcb_desc_engine #(
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
  ) u_desc_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .held_valid  (held_valid),
    .held_host   (held_host),
    .held_length (held_length),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .desc        (desc)
  );

  assign next_adjacent  = desc.next_adjacent;
  assign control_bits   = desc.control_bits;
  assign desc_length    = desc.desc_length;
  assign source_address = desc.source_address;
  assign dest_address   = desc.dest_address;
  assign link_address   = desc.link_address;
  assign desc_index     = desc.desc_index;
  assign is_last        = desc.is_last;

endmodule
